>>> rtl/core/murmur3_32_hash_top_defines.svh
// Assertion macros for the hash block.
`ifndef MURMUR3_32_HASH_TOP_DEFINES_SVH
`define MURMUR3_32_HASH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check that the consequent holds whenever the antecedent holds.
`define MM3_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash block: implication check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define MM3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash block: next-cycle check failed");
`else
`define MM3_ASSERT_IMPLIES(label, ante, cons)
`define MM3_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/mm3_pkg.sv
package mm3_pkg;

   localparam logic [31:0] C1         = 32'hcc9e2d51;
   localparam logic [31:0] C2         = 32'h1b873593;
   localparam logic [31:0] MIX_N      = 32'he6546b64;
   localparam logic [31:0] F1         = 32'h85ebca6b;
   localparam logic [31:0] F2         = 32'hc2b2ae35;
   localparam logic [31:0] SEED_RESET = 32'hffffffff;

   // datapath step codes
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_K1   = 3'd1;
   localparam logic [2:0] OP_K2   = 3'd2;
   localparam logic [2:0] OP_MIX  = 3'd3;
   localparam logic [2:0] OP_FIN1 = 3'd4;
   localparam logic [2:0] OP_FIN2 = 3'd5;
   localparam logic [2:0] OP_FIN3 = 3'd6;

   typedef struct packed {
      logic       capture;
      logic [2:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic ends_key;
   } dp_sts_type;

endpackage

>>> rtl/core/murmur3_32_hash_top.sv
// MurmurHash3 x86_32 over keys streamed as little-endian 32-bit words.
// A full mid-key word runs accept, two multiplies and mix; a word that ends
// the key also runs the finalizer, all on the one shared 32x32 multiplier.
// A new word waits until the last one is through; rsp_valid rises after FIN3.
// Reset (synchronous, active high): seed returns to 0xffffffff, no key open,
// no result pending.
`include "murmur3_32_hash_top_defines.svh"

module murmur3_32_hash_top (
   input  logic        clock,
   input  logic        reset,
   // key word channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,
   output logic [31:0] rsp_key_length,
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_hash_seed
);

   mm3_pkg::dp_cmd_type cmd;
   mm3_pkg::dp_sts_type sts;

   // The seed register takes a write in any cycle; a running key keeps the
   // seed it loaded, the new one applies at the next key start.
   assign csr_ready = 1'b1;

   // Sequencer: accept a word only in idle, then step the shared multiplier
   // through scramble, mix and, when the key ends, the finalizer.
   mm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: seed, running hash, byte total and the result register.
   // The result register holds while the downstream side stalls, so the next
   // key's words are taken meanwhile.
   mm3_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .csr_write      (csr_valid && csr_ready),
      .csr_hash_seed  (csr_hash_seed),
      .rsp_hash_value (rsp_hash_value),
      .rsp_key_length (rsp_key_length)
   );

   // An accepted word keeps the sequencer busy for the next cycle.
   `MM3_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // A new result is only produced by the finalizer, never from idle.
   `MM3_ASSERT_IMPLIES(a_result_from_busy, $rose(rsp_valid), $past(req_stall))

endmodule

>>> rtl/core/mm3_ctrl.sv
module mm3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  mm3_pkg::dp_sts_type sts,
   output mm3_pkg::dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_K1   = 3'd1;
   localparam logic [2:0] ST_K2   = 3'd2;
   localparam logic [2:0] ST_MIX  = 3'd3;
   localparam logic [2:0] ST_FIN1 = 3'd4;
   localparam logic [2:0] ST_FIN2 = 3'd5;
   localparam logic [2:0] ST_FIN3 = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.op      = mm3_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_K1;
            end
         end
         ST_K1: begin
            cmd.op   = mm3_pkg::OP_K1;
            state_in = ST_K2;
         end
         ST_K2: begin
            cmd.op   = mm3_pkg::OP_K2;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.op   = mm3_pkg::OP_MIX;
            state_in = sts.ends_key ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            cmd.op   = mm3_pkg::OP_FIN1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.op   = mm3_pkg::OP_FIN2;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.op   = mm3_pkg::OP_FIN3;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.op == mm3_pkg::OP_FIN3) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/mm3_datapath.sv
module mm3_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mm3_pkg::dp_cmd_type cmd,
   output mm3_pkg::dp_sts_type sts,
   input  logic [31:0]         req_data_word,
   input  logic [2:0]          req_byte_count,
   input  logic                req_last_word,
   input  logic                csr_write,
   input  logic [31:0]         csr_hash_seed,
   output logic [31:0]         rsp_hash_value,
   output logic [31:0]         rsp_key_length
);

   logic [31:0] seed_ff, seed_in;
   logic        key_open_ff, key_open_in;
   logic [31:0] word_ff, word_in;
   logic        full_ff, full_in;
   logic        last_ff, last_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] hash_out_ff, hash_out_in;
   logic [31:0] len_out_ff, len_out_in;

   logic [2:0]  cnt;
   logic [31:0] mask;
   logic [31:0] mul_a, mul_b, prod;
   logic [31:0] fin_x, fin_y, mix_h;

   assign sts.ends_key   = !full_ff || last_ff;
   assign rsp_hash_value = hash_out_ff;
   assign rsp_key_length = len_out_ff;

   // clamp counts above four to a full word
   always_comb begin
      case (req_byte_count)
         3'd0:    begin cnt = 3'd0; mask = 32'h00000000; end
         3'd1:    begin cnt = 3'd1; mask = 32'h000000ff; end
         3'd2:    begin cnt = 3'd2; mask = 32'h0000ffff; end
         3'd3:    begin cnt = 3'd3; mask = 32'h00ffffff; end
         default: begin cnt = 3'd4; mask = 32'hffffffff; end
      endcase
   end

   assign fin_x = (h_ff ^ total_ff) ^ ((h_ff ^ total_ff) >> 16);
   assign fin_y = h_ff ^ (h_ff >> 13);
   assign mix_h = h_ff ^ k_ff;

   // one shared 32x32 multiplier, low word only
   always_comb begin
      case (cmd.op)
         mm3_pkg::OP_K2:   begin mul_a = {k_ff[16:0], k_ff[31:17]}; mul_b = mm3_pkg::C2; end
         mm3_pkg::OP_FIN1: begin mul_a = fin_x; mul_b = mm3_pkg::F1; end
         mm3_pkg::OP_FIN2: begin mul_a = fin_y; mul_b = mm3_pkg::F2; end
         default:          begin mul_a = word_ff; mul_b = mm3_pkg::C1; end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      seed_in     = csr_write ? csr_hash_seed : seed_ff;
      key_open_in = key_open_ff;
      word_in     = word_ff;
      full_in     = full_ff;
      last_in     = last_ff;
      h_in        = h_ff;
      k_in        = k_ff;
      total_in    = total_ff;
      hash_out_in = hash_out_ff;
      len_out_in  = len_out_ff;
      if (cmd.capture) begin
         word_in     = req_data_word & mask;
         full_in     = (cnt == 3'd4);
         last_in     = req_last_word;
         h_in        = key_open_ff ? h_ff : seed_ff;
         total_in    = (key_open_ff ? total_ff : 32'd0) + {29'd0, cnt};
         key_open_in = 1'b1;
      end
      case (cmd.op)
         mm3_pkg::OP_K1: k_in = prod;
         mm3_pkg::OP_K2: k_in = prod;
         mm3_pkg::OP_MIX: begin
            if (full_ff) begin
               h_in = ({mix_h[18:0], mix_h[31:19]} << 2) + {mix_h[18:0], mix_h[31:19]}
                      + mm3_pkg::MIX_N;
            end else begin
               h_in = mix_h;
            end
         end
         mm3_pkg::OP_FIN1: h_in = prod;
         mm3_pkg::OP_FIN2: h_in = prod;
         mm3_pkg::OP_FIN3: begin
            hash_out_in = h_ff ^ (h_ff >> 16);
            len_out_in  = total_ff;
            key_open_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= mm3_pkg::SEED_RESET;
         key_open_ff <= 1'b0;
      end else begin
         seed_ff     <= seed_in;
         key_open_ff <= key_open_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      full_ff     <= full_in;
      last_ff     <= last_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      total_ff    <= total_in;
      hash_out_ff <= hash_out_in;
      len_out_ff  <= len_out_in;
   end

endmodule

>>> test/murmur3_32_hash_checker.sv
`timescale 1ns / 1ps

module murmur3_32_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_hash_value,
   input  logic [31:0] rsp_key_length,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_hash_seed,
   output int          fail_count,
   output int          pending_digests
);

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] key_length;
   } key_digest_type;

   key_digest_type digest_q[$];

   logic [31:0] seed_reg;
   logic [31:0] running_hash;
   logic [31:0] byte_total;
   logic        key_open;

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_block(input logic [31:0] k);
      logic [31:0] t;
      t = k * mm3_pkg::C1;
      t = rotate_left(t, 15);
      t = t * mm3_pkg::C2;
      return t;
   endfunction

   function automatic logic [31:0] finalize_hash(input logic [31:0] h_in);
      logic [31:0] h;
      h = h_in;
      h = h ^ (h >> 16);
      h = h * mm3_pkg::F1;
      h = h ^ (h >> 13);
      h = h * mm3_pkg::F2;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // Fold one key word into the running hash; return 1 when the key closes.
   function automatic bit fold_key_word(input logic [31:0] w, input logic [2:0] cnt_in,
                                        input logic last, output key_digest_type d);
      logic [31:0] h;
      logic [31:0] mask;
      logic [2:0]  cnt;
      d = '0;
      cnt = (cnt_in > 3'd4) ? 3'd4 : cnt_in;
      if (!key_open) begin
         running_hash = seed_reg;
         byte_total = 32'd0;
      end
      h = running_hash;
      if (cnt == 3'd4) begin
         h = h ^ scramble_block(w);
         h = rotate_left(h, 13);
         h = h * 32'd5 + mm3_pkg::MIX_N;
         byte_total = byte_total + 32'd4;
         if (!last) begin
            running_hash = h;
            key_open = 1'b1;
            return 1'b0;
         end
      end else begin
         if (cnt != 3'd0) begin
            mask = (32'd1 << (8 * cnt)) - 32'd1;
            h = h ^ scramble_block(w & mask);
         end
         byte_total = byte_total + {29'd0, cnt};
      end
      h = finalize_hash(h ^ byte_total);
      d.hash_value = h;
      d.key_length = byte_total;
      running_hash = h;
      key_open = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      key_digest_type d;
      key_digest_type want;
      if (reset) begin
         seed_reg = mm3_pkg::SEED_RESET;
         running_hash = 32'd0;
         byte_total = 32'd0;
         key_open = 1'b0;
         fail_count = 0;
         digest_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            seed_reg = csr_hash_seed;
         if (req_valid && !req_stall) begin
            if (fold_key_word(req_data_word, req_byte_count, req_last_word, d))
               digest_q.push_back(d);
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected result: hash %h length %h", $time,
                        rsp_hash_value, rsp_key_length);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_hash_value !== want.hash_value) begin
                  $display("%0t: hash_value mismatch: expected %h, got %h", $time,
                           want.hash_value, rsp_hash_value);
                  fail_count++;
               end
               if (rsp_key_length !== want.key_length) begin
                  $display("%0t: key_length mismatch: expected %h, got %h", $time,
                           want.key_length, rsp_key_length);
                  fail_count++;
               end
            end
         end
      end
      pending_digests = digest_q.size();
   end

endmodule

>>> test/murmur3_32_hash_top_tb.sv
`timescale 1ns / 1ps

module murmur3_32_hash_top_tb;

   // Budget in clock cycles for the whole run; far above the slowest legal run.
   localparam int CYCLE_LIMIT = 400000;
   // Quiet cycles before a seed write or the verdict; lets a word in flight finish.
   localparam int SETTLE_CYCLES = 16;
   // Length of the one long receiver hold-off.
   localparam int HOLD_CYCLES = 400;
   localparam int WORDS_PER_PHASE = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_data_word;
   logic [2:0]  req_byte_count;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_hash_value;
   logic [31:0] rsp_key_length;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_hash_seed;

   int fail_count;
   int pending_digests;
   int words_sent;
   int send_idle_pct;
   int stall_pct;
   int cycle_count;
   logic long_hold_req;

   murmur3_32_hash_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .rsp_key_length (rsp_key_length),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_hash_seed  (csr_hash_seed)
   );

   murmur3_32_hash_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash_value  (rsp_hash_value),
      .rsp_key_length  (rsp_key_length),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_seed   (csr_hash_seed),
      .fail_count      (fail_count),
      .pending_digests (pending_digests)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: count cycles and end the run if the block hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random stall at the current rate, plus one long hold-off
   // on request. The hold-off is counted here so the sender keeps offering
   // words while results back up and the block stalls its input.
   initial begin
      int  hold_left;
      bit  hold_taken;
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Offer one key word after a random gap; return at the falling edge after
   // it is taken, leaving valid high so a back-to-back word follows cleanly.
   task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= w;
      req_byte_count <= cnt;
      req_last_word  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_digests != 0) @(negedge clock);
   endtask

   // Drain, let a trailing full word finish, then write the seed.
   task automatic write_seed(input logic [31:0] seed);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_hash_seed <= seed;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One well-formed key: a run of full words (mostly short, now and then
   // long, sometimes with an oversized count) and a closing word.
   task automatic send_random_key();
      int n_full;
      if ($urandom_range(0, 9) < 7)
         n_full = $urandom_range(0, 3);
      else
         n_full = $urandom_range(4, 12);
      for (int i = 0; i < n_full; i++)
         send_word($urandom(), ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'd4,
                   1'b0);
      case ($urandom_range(0, 5))
         0, 1, 2, 3: send_word($urandom(), 3'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         4:          send_word($urandom(), 3'd4, 1'b1);
         default:    send_word($urandom(), 3'($urandom_range(5, 7)), 1'b1);
      endcase
   endtask

   initial begin
      int target;
      int keys;
      int phase;
      logic [31:0] seed;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_word  = 32'd0;
      req_byte_count = 3'd0;
      req_last_word  = 1'b0;
      csr_valid      = 1'b0;
      csr_hash_seed  = 32'd0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      words_sent     = 0;
      long_hold_req  = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset seed: empty key, each tail size with junk above
      // the valid bytes, full word that closes the key.
      send_word(32'hffffffff, 3'd0, 1'b0);
      send_word(32'hffffff80, 3'd1, 1'b0);
      send_word(32'h5a5a0001, 3'd2, 1'b1);
      send_word(32'hff7f8000, 3'd3, 1'b0);
      send_word(32'hffffffff, 3'd4, 1'b1);
      // two full words and a three-byte tail
      send_word(32'h00000000, 3'd4, 1'b0);
      send_word(32'h80000001, 3'd4, 1'b0);
      send_word(32'h00abcdef, 3'd3, 1'b1);
      // oversized counts act as full words, the last one closing the key
      send_word(32'h12345678, 3'd5, 1'b0);
      send_word(32'h9abcdef0, 3'd6, 1'b0);
      send_word(32'hdeadbeef, 3'd7, 1'b1);
      // a full word followed by an empty tail
      send_word(32'hcafef00d, 3'd4, 1'b0);
      send_word(32'hffffffff, 3'd0, 1'b1);
      // zero seed: the empty key hashes to zero
      write_seed(32'h00000000);
      send_word(32'h00000000, 3'd0, 1'b1);
      // seed changed mid-key: the open key keeps the zero seed, the next
      // key picks up the new one
      send_word(32'h01020304, 3'd4, 1'b0);
      write_seed(32'h12345678);
      send_word(32'h0000beef, 3'd2, 1'b1);
      send_word(32'h76543210, 3'd4, 1'b1);

      // Random part in four phases, each with its own seed.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       seed = 32'hffffffff;
            2:       seed = 32'h00000000;
            default: seed = $urandom();
         endcase
         write_seed(seed);
         send_idle_pct = (phase == 1) ? 60 : (phase == 3) ? 31 : 0;
         stall_pct     = (phase == 2) ? 60 : (phase == 3) ? 31 : 0;
         // back up the result side while the sender keeps pushing
         if (phase == 0)
            long_hold_req <= 1'b1;
         target = words_sent + WORDS_PER_PHASE;
         keys = 0;
         while (words_sent < target) begin
            send_random_key();
            keys++;
            // pause the sender until the block has caught up
            if (phase == 1 && keys % 40 == 0)
               wait_for_results();
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
